// File: src/delayline_mcp_time_reconstruct_top_macros.svh
// ----------------------------------------------------------------------------
// Delay-line MCP time reconstruction - assertion macros
// Shared property shapes for the port checker.
// ----------------------------------------------------------------------------
`ifndef DELAYLINE_MCP_TIME_RECONSTRUCT_TOP_MACROS_SVH
`define DELAYLINE_MCP_TIME_RECONSTRUCT_TOP_MACROS_SVH

// same-cycle implication
`define DLMCP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dlmcp port check failed");

// next-cycle implication
`define DLMCP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dlmcp port check failed");

`endif

// File: src/dlmcp_pkg.sv
// ----------------------------------------------------------------------------
// dlmcp_pkg
// Types and constants shared by the delay-line MCP time reconstruction block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dlmcp_pkg;

  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int IDX_W     = 4;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD1 = 2'd0,
    OP_LOAD2 = 2'd1,
    OP_CLEAR = 2'd2,
    OP_FIND  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_PAIR = 2'd2,
    ST_NONE = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SORT1_LOW  = 3'd0,
    CFG_SORT1_HIGH = 3'd1,
    CFG_SORT2_LOW  = 3'd2,
    CFG_SORT2_HIGH = 3'd3,
    CFG_TSUM_LOW   = 3'd4,
    CFG_TSUM_HIGH  = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OUTER,
    S_T1,
    S_SEEK,
    S_SEEK_CHK,
    S_SCAN,
    S_SCAN_CHK,
    S_WIN_LO,
    S_WIN_HI
  } state_t;

  typedef enum logic [1:0] {
    ALU_SEEK,
    ALU_SCAN,
    ALU_WIN_LO,
    ALU_WIN_HI
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    logic    load_t1;
    logic    load_mcp;
  } alu_ctl_t;

endpackage

`default_nettype wire

// File: src/dlmcp_hitmem.sv
// ----------------------------------------------------------------------------
// dlmcp_hitmem
// Hit time list storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlmcp_hitmem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 24,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: src/dlmcp_alu.sv
// ----------------------------------------------------------------------------
// dlmcp_alu
// Shared compare unit, MCP time register and output saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlmcp_alu #(
  parameter int TIME_BITS = 24,
  parameter int DW        = 28
) (
  input  logic                           clk,
  input  dlmcp_pkg::alu_ctl_t            ctl,
  input  logic signed [TIME_BITS-1:0]    t1_in,
  input  logic signed [TIME_BITS-1:0]    t2_in,
  input  logic signed [DW-1:0]           w_sum,
  input  logic signed [DW-1:0]           t_sum,
  input  logic signed [dlmcp_pkg::CFG_W-1:0] sort1_low,
  input  logic signed [dlmcp_pkg::CFG_W-1:0] sort1_high,
  output logic                           lt,
  output logic signed [TIME_BITS-1:0]    mcp_sat
);

  import dlmcp_pkg::*;

  localparam logic signed [DW-1:0] SAT_HI =
    DW'((longint'(1) <<< (TIME_BITS - 1)) - longint'(1));
  localparam logic signed [DW-1:0] SAT_LO = -SAT_HI - DW'(1);

  logic signed [TIME_BITS-1:0] t1_r;
  logic signed [DW-1:0]        mcp_r;
  logic signed [DW-1:0]        mcp_nxt;
  logic signed [DW-1:0]        t1_x;
  logic signed [DW-1:0]        t2_x;
  logic signed [DW-1:0]        lo_x;
  logic signed [DW-1:0]        hi_x;
  logic signed [DW-1:0]        win_x;
  logic signed [DW-1:0]        lhs;
  logic signed [DW-1:0]        rhs;
  logic signed [DW-1:0]        mcp_clamp;

  assign t1_x = {{(DW-TIME_BITS){t1_r[TIME_BITS-1]}}, t1_r};
  assign t2_x = {{(DW-TIME_BITS){t2_in[TIME_BITS-1]}}, t2_in};
  assign lo_x = {{(DW-CFG_W){sort1_low[CFG_W-1]}}, sort1_low};
  assign hi_x = {{(DW-CFG_W){sort1_high[CFG_W-1]}}, sort1_high};

  assign win_x   = t1_x - mcp_r;
  assign mcp_nxt = (((t1_x + t2_x) <<< 1) - t_sum) >>> 2;

  always_comb begin
    case (ctl.op)
      ALU_SEEK: begin
        lhs = t2_x <<< 1;
        rhs = (t1_x <<< 1) - w_sum;
      end
      ALU_SCAN: begin
        lhs = t2_x <<< 1;
        rhs = (t1_x <<< 1) + w_sum;
      end
      ALU_WIN_LO: begin
        lhs = win_x;
        rhs = lo_x;
      end
      default: begin
        lhs = win_x;
        rhs = hi_x;
      end
    endcase
  end

  assign lt = (lhs < rhs);

  always_ff @(posedge clk) begin
    if (ctl.load_t1) begin
      t1_r <= t1_in;
    end
    if (ctl.load_mcp) begin
      mcp_r <= mcp_nxt;
    end
  end

  always_comb begin
    if (mcp_r > SAT_HI) begin
      mcp_clamp = SAT_HI;
    end else if (mcp_r < SAT_LO) begin
      mcp_clamp = SAT_LO;
    end else begin
      mcp_clamp = mcp_r;
    end
  end

  assign mcp_sat = mcp_clamp[TIME_BITS-1:0];

endmodule

`default_nettype wire

// File: src/dlmcp_seq.sv
// ----------------------------------------------------------------------------
// dlmcp_seq
// Request handshake, list counts and cursors, find sequencer, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlmcp_seq #(
  parameter int HITS_PER_LIST = 16,
  parameter int TIME_BITS     = 24,
  localparam int AW           = $clog2(HITS_PER_LIST)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [dlmcp_pkg::OP_W-1:0]        in_operation,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dlmcp_pkg::STATUS_W-1:0]    out_status,
  output logic [dlmcp_pkg::IDX_W-1:0]       out_first_index,
  output logic [dlmcp_pkg::IDX_W-1:0]       out_second_index,
  output logic signed [TIME_BITS-1:0]       out_mcp_time,
  output dlmcp_pkg::alu_ctl_t               alu_ctl,
  input  logic                              lt,
  input  logic signed [TIME_BITS-1:0]       mcp_sat,
  output logic                              wr1_en,
  output logic                              wr2_en,
  output logic [AW-1:0]                     wr1_addr,
  output logic [AW-1:0]                     wr2_addr,
  output logic [AW-1:0]                     rd1_addr,
  output logic [AW-1:0]                     rd2_addr
);

  import dlmcp_pkg::*;

  localparam int CW = $clog2(HITS_PER_LIST + 1);
  localparam logic [CW-1:0] FULL = CW'(HITS_PER_LIST);
  localparam logic [CW-1:0] ONE  = CW'(1);

  state_t state_r, state_nxt;
  logic [CW-1:0] fcnt_r, fcnt_nxt;
  logic [CW-1:0] scnt_r, scnt_nxt;
  logic [CW-1:0] fcur_r, fcur_nxt;
  logic [CW-1:0] scur_r, scur_nxt;
  logic          seek_r, seek_nxt;
  logic          adv_r, adv_nxt;
  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r, out_status_nxt;
  logic [IDX_W-1:0] out_fidx_r, out_fidx_nxt;
  logic [IDX_W-1:0] out_sidx_r, out_sidx_nxt;
  logic signed [TIME_BITS-1:0] out_mcp_r, out_mcp_nxt;

  logic in_acc;
  logic f_more;
  logic s_more;

  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign f_more   = (fcur_r < fcnt_r);
  assign s_more   = (scur_r < scnt_r);

  assign wr1_addr = fcnt_r[AW-1:0];
  assign wr2_addr = scnt_r[AW-1:0];
  assign rd1_addr = fcur_r[AW-1:0];
  assign rd2_addr = scur_r[AW-1:0];

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_first_index  = out_fidx_r;
  assign out_second_index = out_sidx_r;
  assign out_mcp_time     = out_mcp_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_operation == OP_FIND)) begin
          state_nxt = S_OUTER;
        end
      end
      S_OUTER:    state_nxt = f_more ? S_T1 : S_IDLE;
      S_T1:       state_nxt = seek_r ? S_SEEK : S_SCAN;
      S_SEEK:     state_nxt = s_more ? S_SEEK_CHK : S_SCAN;
      S_SEEK_CHK: state_nxt = lt ? S_SEEK : S_SCAN;
      S_SCAN:     state_nxt = s_more ? S_SCAN_CHK : S_OUTER;
      S_SCAN_CHK: state_nxt = lt ? S_WIN_LO : S_OUTER;
      S_WIN_LO:   state_nxt = lt ? S_SCAN : S_WIN_HI;
      S_WIN_HI:   state_nxt = lt ? S_IDLE : S_SCAN;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath control and register updates
  always_comb begin
    fcnt_nxt       = fcnt_r;
    scnt_nxt       = scnt_r;
    fcur_nxt       = fcur_r;
    scur_nxt       = scur_r;
    seek_nxt       = seek_r;
    adv_nxt        = adv_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_fidx_nxt   = out_fidx_r;
    out_sidx_nxt   = out_sidx_r;
    out_mcp_nxt    = out_mcp_r;
    wr1_en         = 1'b0;
    wr2_en         = 1'b0;
    alu_ctl.op       = ALU_SEEK;
    alu_ctl.load_t1  = 1'b0;
    alu_ctl.load_mcp = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_fidx_nxt   = '0;
          out_sidx_nxt   = '0;
          out_mcp_nxt    = '0;
          unique case (in_operation)
            OP_LOAD1: begin
              if (fcnt_r < FULL) begin
                wr1_en   = 1'b1;
                fcnt_nxt = fcnt_r + ONE;
              end else begin
                out_status_nxt = ST_FULL;
              end
            end
            OP_LOAD2: begin
              if (scnt_r < FULL) begin
                wr2_en   = 1'b1;
                scnt_nxt = scnt_r + ONE;
              end else begin
                out_status_nxt = ST_FULL;
              end
            end
            OP_CLEAR: begin
              fcnt_nxt = '0;
              scnt_nxt = '0;
              fcur_nxt = '0;
              scur_nxt = '0;
              seek_nxt = 1'b1;
              adv_nxt  = 1'b0;
            end
            default: begin
              // find: result comes at the end of the search
              out_valid_nxt = 1'b0;
              if (adv_r && s_more) begin
                scur_nxt = scur_r + ONE;
              end
              adv_nxt = 1'b0;
            end
          endcase
        end
      end
      S_OUTER: begin
        if (!f_more) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NONE;
          out_fidx_nxt   = '0;
          out_sidx_nxt   = '0;
          out_mcp_nxt    = '0;
        end
      end
      S_T1: begin
        alu_ctl.load_t1 = 1'b1;
        if (seek_r) begin
          scur_nxt = '0;
        end
      end
      S_SEEK: begin
        if (!s_more) begin
          seek_nxt = 1'b0;
        end
      end
      S_SEEK_CHK: begin
        alu_ctl.op = ALU_SEEK;
        if (lt) begin
          scur_nxt = scur_r + ONE;
        end else begin
          seek_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        if (!s_more) begin
          fcur_nxt = fcur_r + ONE;
          seek_nxt = 1'b1;
        end
      end
      S_SCAN_CHK: begin
        alu_ctl.op       = ALU_SCAN;
        alu_ctl.load_mcp = 1'b1;
        if (!lt) begin
          fcur_nxt = fcur_r + ONE;
          seek_nxt = 1'b1;
        end
      end
      S_WIN_LO: begin
        alu_ctl.op = ALU_WIN_LO;
        if (lt) begin
          scur_nxt = scur_r + ONE;
        end
      end
      S_WIN_HI: begin
        alu_ctl.op = ALU_WIN_HI;
        if (lt) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_PAIR;
          out_fidx_nxt   = IDX_W'(fcur_r);
          out_sidx_nxt   = IDX_W'(scur_r);
          out_mcp_nxt    = mcp_sat;
          adv_nxt        = 1'b1;
        end else begin
          scur_nxt = scur_r + ONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fcnt_r      <= '0;
      scnt_r      <= '0;
      fcur_r      <= '0;
      scur_r      <= '0;
      seek_r      <= 1'b1;
      adv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fcnt_r      <= fcnt_nxt;
      scnt_r      <= scnt_nxt;
      fcur_r      <= fcur_nxt;
      scur_r      <= scur_nxt;
      seek_r      <= seek_nxt;
      adv_r       <= adv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_fidx_r   <= out_fidx_nxt;
    out_sidx_r   <= out_sidx_nxt;
    out_mcp_r    <= out_mcp_nxt;
  end

endmodule

`default_nettype wire

// File: src/delayline_mcp_time_reconstruct_top.sv
// ----------------------------------------------------------------------------
// delayline_mcp_time_reconstruct_top
// Pairs first-end and second-end delay-line hits and rebuilds the MCP time.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid/in_stall    in_operation, in_hit_time
//   out_     out  out_valid/out_stall  out_status, out_first_index,
//                                      out_second_index, out_mcp_time
//   cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Load and clear requests return their result in the following cycle. A find
// visits each first-end hit in turn, seeks through the second-end list, tries
// each second-end hit against the windows, closes each seek or scan, and reports
// when no pair is left; the registered read of the hit memories sets its pace.
// No new request is taken while a find runs or a result is stalled.
// Reset clears counts, cursors and configuration; no memory clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module delayline_mcp_time_reconstruct_top #(
  parameter int HITS_PER_LIST = 16,
  parameter int TIME_BITS     = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [dlmcp_pkg::OP_W-1:0]           in_operation,
  input  logic signed [TIME_BITS-1:0]          in_hit_time,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [dlmcp_pkg::STATUS_W-1:0]       out_status,
  output logic [dlmcp_pkg::IDX_W-1:0]          out_first_index,
  output logic [dlmcp_pkg::IDX_W-1:0]          out_second_index,
  output logic signed [TIME_BITS-1:0]          out_mcp_time,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dlmcp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dlmcp_pkg::CFG_W-1:0]          cfg_data
);

  import dlmcp_pkg::*;

  localparam int AW = $clog2(HITS_PER_LIST);
  localparam int DW = ((TIME_BITS > CFG_W) ? TIME_BITS : CFG_W) + 4;

  logic signed [CFG_W-1:0] sort1_low_r, sort1_high_r;
  logic signed [CFG_W-1:0] sort2_low_r, sort2_high_r;
  logic signed [CFG_W-1:0] tsum_low_r, tsum_high_r;
  logic signed [DW-1:0]    w_sum_r, t_sum_r;
  logic signed [DW-1:0]    s1l_x, s1h_x, s2l_x, s2h_x, tl_x, th_x;

  alu_ctl_t alu_ctl;
  logic     lt;
  logic signed [TIME_BITS-1:0] mcp_sat;
  logic signed [TIME_BITS-1:0] t1_rd, t2_rd;
  logic            wr1_en, wr2_en;
  logic [AW-1:0]   wr1_addr, wr2_addr, rd1_addr, rd2_addr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort1_low_r  <= '0;
      sort1_high_r <= '0;
      sort2_low_r  <= '0;
      sort2_high_r <= '0;
      tsum_low_r   <= '0;
      tsum_high_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SORT1_LOW:  sort1_low_r  <= cfg_data;
        CFG_SORT1_HIGH: sort1_high_r <= cfg_data;
        CFG_SORT2_LOW:  sort2_low_r  <= cfg_data;
        CFG_SORT2_HIGH: sort2_high_r <= cfg_data;
        CFG_TSUM_LOW:   tsum_low_r   <= cfg_data;
        CFG_TSUM_HIGH:  tsum_high_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign s1l_x = {{(DW-CFG_W){sort1_low_r[CFG_W-1]}}, sort1_low_r};
  assign s1h_x = {{(DW-CFG_W){sort1_high_r[CFG_W-1]}}, sort1_high_r};
  assign s2l_x = {{(DW-CFG_W){sort2_low_r[CFG_W-1]}}, sort2_low_r};
  assign s2h_x = {{(DW-CFG_W){sort2_high_r[CFG_W-1]}}, sort2_high_r};
  assign tl_x  = {{(DW-CFG_W){tsum_low_r[CFG_W-1]}}, tsum_low_r};
  assign th_x  = {{(DW-CFG_W){tsum_high_r[CFG_W-1]}}, tsum_high_r};

  // summed window width and time-sum (twice the centre)
  always_ff @(posedge clk) begin
    w_sum_r <= (s1h_x - s1l_x) + (s2h_x - s2l_x);
    t_sum_r <= tl_x + th_x;
  end

  dlmcp_hitmem #(
    .DEPTH (HITS_PER_LIST),
    .WIDTH (TIME_BITS)
  ) u_mem1 (
    .clk     (clk),
    .wr_en   (wr1_en),
    .wr_addr (wr1_addr),
    .wr_data (in_hit_time),
    .rd_addr (rd1_addr),
    .rd_data (t1_rd)
  );

  dlmcp_hitmem #(
    .DEPTH (HITS_PER_LIST),
    .WIDTH (TIME_BITS)
  ) u_mem2 (
    .clk     (clk),
    .wr_en   (wr2_en),
    .wr_addr (wr2_addr),
    .wr_data (in_hit_time),
    .rd_addr (rd2_addr),
    .rd_data (t2_rd)
  );

  dlmcp_alu #(
    .TIME_BITS (TIME_BITS),
    .DW        (DW)
  ) u_alu (
    .clk        (clk),
    .ctl        (alu_ctl),
    .t1_in      (t1_rd),
    .t2_in      (t2_rd),
    .w_sum      (w_sum_r),
    .t_sum      (t_sum_r),
    .sort1_low  (sort1_low_r),
    .sort1_high (sort1_high_r),
    .lt         (lt),
    .mcp_sat    (mcp_sat)
  );

  dlmcp_seq #(
    .HITS_PER_LIST (HITS_PER_LIST),
    .TIME_BITS     (TIME_BITS)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_first_index  (out_first_index),
    .out_second_index (out_second_index),
    .out_mcp_time     (out_mcp_time),
    .alu_ctl          (alu_ctl),
    .lt               (lt),
    .mcp_sat          (mcp_sat),
    .wr1_en           (wr1_en),
    .wr2_en           (wr2_en),
    .wr1_addr         (wr1_addr),
    .wr2_addr         (wr2_addr),
    .rd1_addr         (rd1_addr),
    .rd2_addr         (rd2_addr)
  );

endmodule

`default_nettype wire

// File: src/dlmcp_checker.sv
// ----------------------------------------------------------------------------
// dlmcp_checker
// Port-level checks for the delay-line MCP time reconstruction block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "delayline_mcp_time_reconstruct_top_macros.svh"

module dlmcp_checker #(
  parameter int TIME_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [dlmcp_pkg::OP_W-1:0]        in_operation,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [dlmcp_pkg::STATUS_W-1:0]    out_status,
  input  logic [dlmcp_pkg::IDX_W-1:0]       out_first_index,
  input  logic [dlmcp_pkg::IDX_W-1:0]       out_second_index,
  input  logic signed [TIME_BITS-1:0]       out_mcp_time
);

  import dlmcp_pkg::*;

  `DLMCP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_first_index) && $stable(out_second_index) && $stable(out_mcp_time))
  `DLMCP_ASSERT_IMP(a_nopair_zero, clk, rst_n, out_valid && (out_status != ST_PAIR), (out_first_index == '0) && (out_second_index == '0) && (out_mcp_time == '0))
  `DLMCP_ASSERT_NXT(a_quick_req, clk, rst_n, in_valid && !in_stall && (in_operation != OP_FIND), out_valid)
  `DLMCP_ASSERT_NXT(a_find_busy, clk, rst_n, in_valid && !in_stall && (in_operation == OP_FIND), !out_valid && in_stall)

endmodule

bind delayline_mcp_time_reconstruct_top dlmcp_checker #(
  .TIME_BITS (TIME_BITS)
) u_dlmcp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_operation     (in_operation),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_first_index  (out_first_index),
  .out_second_index (out_second_index),
  .out_mcp_time     (out_mcp_time)
);

`default_nettype wire

// File: verif/dlmcp_pair_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlmcp_pair_checker
// Watches the request, result and register channels of the delay-line MCP
// reconstruction block. It keeps its own copy of the hit lists, cursors and
// windows, predicts the result of every accepted request, and compares each
// returned result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module dlmcp_pair_checker #(
  parameter int HITS_PER_LIST = 16,
  parameter int TIME_BITS     = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [dlmcp_pkg::OP_W-1:0]         in_operation,
  input  logic signed [TIME_BITS-1:0]        in_hit_time,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [dlmcp_pkg::STATUS_W-1:0]     out_status,
  input  logic [dlmcp_pkg::IDX_W-1:0]        out_first_index,
  input  logic [dlmcp_pkg::IDX_W-1:0]        out_second_index,
  input  logic signed [TIME_BITS-1:0]        out_mcp_time,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [dlmcp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dlmcp_pkg::CFG_W-1:0]        cfg_data,
  output int                                 errors,
  output int                                 pending
);

  import dlmcp_pkg::*;

  typedef struct packed {
    status_t              status;
    logic [IDX_W-1:0]     first_index;
    logic [IDX_W-1:0]     second_index;
    logic [TIME_BITS-1:0] mcp_time;
  } pair_result_t;

  longint win1_lo, win1_hi, win2_lo, win2_hi, tsum_lo, tsum_hi;
  longint first_times[HITS_PER_LIST];
  longint second_times[HITS_PER_LIST];
  int     n_first, n_second, cur_first, cur_second;
  bit     reseek, skip_last_pair;

  pair_result_t expected_q[$];

  task automatic clear_lists();
    n_first        = 0;
    n_second       = 0;
    cur_first      = 0;
    cur_second     = 0;
    reseek         = 1'b1;
    skip_last_pair = 1'b0;
  endtask

  task automatic apply_window(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    longint v;
    v = longint'($signed(data));
    case (cfg_idx_t'(idx))
      CFG_SORT1_LOW:  win1_lo = v;
      CFG_SORT1_HIGH: win1_hi = v;
      CFG_SORT2_LOW:  win2_lo = v;
      CFG_SORT2_HIGH: win2_hi = v;
      CFG_TSUM_LOW:   tsum_lo = v;
      CFG_TSUM_HIGH:  tsum_hi = v;
      default: ;
    endcase
  endtask

  task automatic reconstruct(input op_t op, input longint t, output pair_result_t r);
    longint w, tsum, t1, t2, mcp, x, t_max, t_min;
    int     k;
    bit     found;
    r        = '0;
    r.status = ST_OK;
    case (op)
      OP_LOAD1: begin
        if (n_first < HITS_PER_LIST) begin
          first_times[n_first] = t;
          n_first++;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_LOAD2: begin
        if (n_second < HITS_PER_LIST) begin
          second_times[n_second] = t;
          n_second++;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_CLEAR: clear_lists();
      default: begin
        w     = win1_hi - win1_lo + win2_hi - win2_lo;
        tsum  = tsum_lo + tsum_hi;
        found = 1'b0;
        if (skip_last_pair) begin
          if (cur_second < n_second) cur_second++;
          skip_last_pair = 1'b0;
        end
        while (!found && cur_first < n_first) begin
          t1 = first_times[cur_first];
          if (reseek) begin
            k = 0;
            while (k < n_second && 2 * second_times[k] < 2 * t1 - w) k++;
            cur_second = k;
            reseek     = 1'b0;
          end
          while (!found && cur_second < n_second && 2 * second_times[cur_second] < 2 * t1 + w) begin
            t2  = second_times[cur_second];
            mcp = (2 * (t1 + t2) - tsum) >>> 2;
            x   = t1 - mcp;
            if (x >= win1_lo && x < win1_hi) found = 1'b1;
            else cur_second++;
          end
          if (!found) begin
            cur_first++;
            reseek = 1'b1;
          end
        end
        if (found) begin
          t_max = (longint'(1) <<< (TIME_BITS - 1)) - 1;
          t_min = -t_max - 1;
          t1    = first_times[cur_first];
          t2    = second_times[cur_second];
          mcp   = (2 * (t1 + t2) - tsum) >>> 2;
          if (mcp > t_max) mcp = t_max;
          else if (mcp < t_min) mcp = t_min;
          r.status       = ST_PAIR;
          r.first_index  = cur_first[IDX_W-1:0];
          r.second_index = cur_second[IDX_W-1:0];
          r.mcp_time     = mcp[TIME_BITS-1:0];
          skip_last_pair = 1'b1;
        end else begin
          r.status = ST_NONE;
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    pair_result_t want;
    if (!rst_n) begin
      win1_lo = 0;
      win1_hi = 0;
      win2_lo = 0;
      win2_hi = 0;
      tsum_lo = 0;
      tsum_hi = 0;
      clear_lists();
      expected_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) apply_window(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        reconstruct(op_t'(in_operation), longint'(in_hit_time), want);
        expected_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result returned with no request outstanding");
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", want.status, out_status);
          check_field("first_index", want.first_index, out_first_index);
          check_field("second_index", want.second_index, out_second_index);
          check_field("mcp_time", longint'($signed(want.mcp_time)), longint'(out_mcp_time));
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

// File: verif/delayline_mcp_time_reconstruct_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delayline_mcp_time_reconstruct_top_tb
// Drives load, clear and find requests into the MCP reconstruction block
// over several window settings, with random gaps and result back-pressure,
// and leaves prediction and comparison to the pair checker.
// ----------------------------------------------------------------------------
module delayline_mcp_time_reconstruct_top_tb;
  import dlmcp_pkg::*;

  localparam int TIME_BITS = 24;
  localparam int T_MIN     = -8388608;
  localparam int T_MAX     = 8388607;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [OP_W-1:0]             in_operation;
  logic signed [TIME_BITS-1:0] in_hit_time;
  logic                        out_valid;
  logic                        out_stall;
  logic [STATUS_W-1:0]         out_status;
  logic [IDX_W-1:0]            out_first_index;
  logic [IDX_W-1:0]            out_second_index;
  logic signed [TIME_BITS-1:0] out_mcp_time;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_W-1:0]            cfg_data;

  int errors;
  int pending;
  int issued;
  int hold_cycles;
  bit tx_quiet;
  bit rx_quiet;

  delayline_mcp_time_reconstruct_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_hit_time      (in_hit_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_first_index  (out_first_index),
    .out_second_index (out_second_index),
    .out_mcp_time     (out_mcp_time),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  dlmcp_pair_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_hit_time      (in_hit_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_first_index  (out_first_index),
    .out_second_index (out_second_index),
    .out_mcp_time     (out_mcp_time),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .errors           (errors),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("delayline_mcp_time_reconstruct_top_tb failed");
    $finish;
  end

  // result side: random stall per result, plus one long hold-off on request
  initial begin : result_sink
    int n;
    out_stall = 1'b1;
    wait (rst_n === 1'b1);
    forever begin
      n = rx_quiet ? 0 : $urandom_range(0, 16);
      if (hold_cycles > 0) begin
        n = n + hold_cycles;
        hold_cycles = 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send(input op_t op, input int t);
    int gap;
    in_valid     <= 1'b1;
    in_operation <= op;
    in_hit_time  <= t[TIME_BITS-1:0];
    do @(posedge clk); while (in_stall);
    issued++;
    gap = tx_quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_windows(input int s1lo, input int s1hi, input int s2lo,
                                 input int s2hi, input int tlo, input int thi,
                                 input bit spare);
    settle();
    write_reg(CFG_SORT1_LOW, s1lo);
    write_reg(CFG_SORT1_HIGH, s1hi);
    write_reg(CFG_SORT2_LOW, s2lo);
    write_reg(CFG_SORT2_HIGH, s2hi);
    write_reg(CFG_TSUM_LOW, tlo);
    write_reg(CFG_TSUM_HIGH, thi);
    if (spare) begin
      write_reg(CFG_SPARE_A, $urandom);
      write_reg(CFG_SPARE_B, $urandom);
    end
    cfg_valid <= 1'b0;
  endtask

  // one event: clear, interleaved loads of both lists, then a run of finds
  task automatic hit_burst(input int spread, input bit sorted, input bit overfull);
    int n1, n2, i1, i2, t1, t2, base, nfind;
    n1 = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 18) : $urandom_range(1, 8);
    n2 = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 18) : $urandom_range(1, 8);
    if (overfull) begin
      n1 = 18;
      n2 = 17;
    end
    base = int'($urandom_range(0, 16000000)) - 8000000;
    t1   = base;
    t2   = base;
    i1   = 0;
    i2   = 0;
    send(OP_CLEAR, $urandom);
    while (i1 < n1 || i2 < n2) begin
      if (i2 >= n2 || (i1 < n1 && $urandom_range(0, 1) == 1)) begin
        t1 = sorted ? t1 + int'($urandom_range(0, spread))
                    : base + int'($urandom_range(0, 8 * spread));
        send(OP_LOAD1, t1);
        i1++;
      end else begin
        t2 = sorted ? t2 + int'($urandom_range(0, spread))
                    : base + int'($urandom_range(0, 8 * spread));
        send(OP_LOAD2, t2);
        i2++;
      end
    end
    nfind = $urandom_range(1, n1 + 3);
    repeat (nfind) send(OP_FIND, $urandom);
  endtask

  task automatic noise_requests();
    repeat ($urandom_range(1, 6)) send(op_t'($urandom_range(0, 3)), $urandom);
  endtask

  initial begin : stimulus
    int ph, a, c, hw, spread, target, pick;
    bit first_burst;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = OP_LOAD1;
    in_hit_time  = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_SORT1_LOW;
    cfg_data     = '0;
    issued       = 0;
    hold_cycles  = 0;
    tx_quiet     = 1'b0;
    rx_quiet     = 1'b0;
    first_burst  = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset windows are all zero: nothing can pair
    send(OP_FIND, 0);
    send(OP_LOAD1, 0);
    send(OP_LOAD2, 0);
    send(OP_FIND, 0);

    program_windows(-100, 100, -100, 100, -20, 20, 1'b0);
    send(OP_CLEAR, 24'h5a5a5a);
    send(OP_LOAD1, T_MIN);
    send(OP_LOAD2, T_MIN);
    send(OP_FIND, T_MAX);
    send(OP_LOAD1, 100);
    send(OP_LOAD2, 90);
    send(OP_LOAD2, 110);
    send(OP_FIND, 0);
    send(OP_FIND, 0);
    send(OP_FIND, 0);
    // hits added after the search ran dry
    send(OP_LOAD1, 200);
    send(OP_LOAD2, 205);
    send(OP_FIND, 0);
    // out-of-order loads
    send(OP_LOAD1, 50);
    send(OP_LOAD2, 40);
    send(OP_FIND, 0);

    // widest windows, time-sum centre at the bottom: mcp saturates high
    program_windows(T_MIN, T_MAX, T_MIN, T_MAX, T_MIN, T_MIN, 1'b1);
    send(OP_CLEAR, 0);
    send(OP_LOAD1, T_MAX);
    send(OP_LOAD2, T_MAX);
    send(OP_FIND, 0);

    for (ph = 0; ph < 6; ph++) begin
      a      = $urandom_range(50, 2000);
      c      = int'($urandom_range(0, 2 * a)) - a;
      hw     = $urandom_range(0, a);
      spread = a;
      case (ph)
        1: begin
          program_windows(T_MIN, T_MAX, T_MIN, T_MAX, T_MIN, T_MAX, 1'b1);
          spread = 20000;
        end
        3: program_windows(-a, a, T_MAX, T_MIN, T_MAX, T_MIN, 1'b0);
        5: program_windows(a, -a, -a, a, c - hw, c + hw, 1'b0);
        default: program_windows(-a, a, -int'($urandom_range(0, a)), a, c - hw, c + hw, 1'b0);
      endcase
      tx_quiet = (ph == 2);
      rx_quiet = (ph == 2);
      if (ph == 2) hold_cycles = 400;
      target = issued + 62;
      while (issued < target) begin
        pick = $urandom_range(0, 9);
        if (first_burst) begin
          hit_burst(spread, 1'b1, 1'b1);
          first_burst = 1'b0;
        end else if (pick < 7) begin
          hit_burst(spread, 1'b1, 1'b0);
        end else if (pick < 9) begin
          noise_requests();
        end else begin
          hit_burst(spread, 1'b0, 1'b0);
        end
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("delayline_mcp_time_reconstruct_top_tb passed");
    end else begin
      $display("delayline_mcp_time_reconstruct_top_tb failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/dlmcp_pkg.sv
src/dlmcp_hitmem.sv
src/dlmcp_alu.sv
src/dlmcp_seq.sv
src/delayline_mcp_time_reconstruct_top.sv
src/dlmcp_checker.sv
verif/dlmcp_pair_checker.sv
verif/delayline_mcp_time_reconstruct_top_tb.sv
